/* hdl/two_modulus_residue_alu_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the two-modulus residue ALU
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_MODULUS_RESIDUE_ALU_UNIT_MACROS_SVH
`define TWO_MODULUS_RESIDUE_ALU_UNIT_MACROS_SVH

// Same-cycle implication.
`define TRMA_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication.
`define TRMA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* hdl/trma_pkg.sv */
// ----------------------------------------------------------------------------
// trma_pkg
// Widths, codes and types shared by the residue ALU files.
// ----------------------------------------------------------------------------
package trma_pkg;

    localparam int OPERAND_WIDTH   = 32;
    localparam int MODULUS_WIDTH   = 16;
    localparam int PRODUCT_WIDTH   = 2 * MODULUS_WIDTH;
    localparam int VALUE_WIDTH     = (OPERAND_WIDTH > PRODUCT_WIDTH) ?
                                     OPERAND_WIDTH : PRODUCT_WIDTH;
    localparam int OP_WIDTH        = 2;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = (OPERAND_WIDTH > MODULUS_WIDTH) ?
                                     OPERAND_WIDTH : MODULUS_WIDTH;

    // Operation codes
    localparam logic [OP_WIDTH-1:0] OP_ADD = 2'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB = 2'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS_A     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS_B     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ELEMENT_COUNT = 2'd2;

    // Data handed from one reduction cell to the next
    typedef struct packed {
        logic [MODULUS_WIDTH-1:0] rem;
        logic [VALUE_WIDTH-1:0]   value;
    } cell_data_t;

    // Control that travels alongside the cell chains
    typedef struct packed {
        logic                valid;
        logic [OP_WIDTH-1:0] op;
        logic                range_err;
    } side_t;

endpackage

/* hdl/trma_in_if.sv */
// ----------------------------------------------------------------------------
// trma_in_if
// Operation channel: valid/ready handshake with operation and two operands.
// ----------------------------------------------------------------------------
interface trma_in_if
    import trma_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [OP_WIDTH-1:0]      operation;
    logic [OPERAND_WIDTH-1:0] left_operand;
    logic [OPERAND_WIDTH-1:0] right_operand;

    modport source (output valid, output operation, output left_operand,
                    output right_operand, input ready);
    modport sink   (input valid, input operation, input left_operand,
                    input right_operand, output ready);
endinterface

/* hdl/trma_out_if.sv */
// ----------------------------------------------------------------------------
// trma_out_if
// Result channel: valid/ready handshake with two residues and an error flag.
// ----------------------------------------------------------------------------
interface trma_out_if
    import trma_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [MODULUS_WIDTH-1:0] residue_a;
    logic [MODULUS_WIDTH-1:0] residue_b;
    logic                     range_error;

    modport source (output valid, output residue_a, output residue_b,
                    output range_error, input ready);
    modport sink   (input valid, input residue_a, input residue_b,
                    input range_error, output ready);
endinterface

/* hdl/two_modulus_residue_alu_unit.sv */
// ----------------------------------------------------------------------------
// two_modulus_residue_alu_unit: residue ALU over two configured moduli
// Stages: first reduction chain, combine register, second chain, output register.
// Throughput: one word per cycle, set by the bit-per-cell chains; the sink can stall it.
// Reset: moduli to 1, element count to 0, pipeline and skid buffer emptied.
// ----------------------------------------------------------------------------
`include "two_modulus_residue_alu_unit_macros.svh"

module two_modulus_residue_alu_unit
    import trma_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]  cfg_data,
    trma_in_if.sink                    op_chan,
    trma_out_if.source                 res_chan
);

    // Lanes of the first chain: left/right operand against modulus a and b
    localparam int LANE_LA = 0;
    localparam int LANE_RA = 1;
    localparam int LANE_LB = 2;
    localparam int LANE_RB = 3;
    localparam int NUM_LANES1 = 4;
    localparam int NUM_LANES2 = 2;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [MODULUS_WIDTH-1:0] mod_a_reg;
    logic [MODULUS_WIDTH-1:0] mod_b_reg;
    logic [OPERAND_WIDTH-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_a_reg <= MODULUS_WIDTH'(1);
            mod_b_reg <= MODULUS_WIDTH'(1);
            count_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODULUS_A:     mod_a_reg <= cfg_data[MODULUS_WIDTH-1:0];
                REG_MODULUS_B:     mod_b_reg <= cfg_data[MODULUS_WIDTH-1:0];
                REG_ELEMENT_COUNT: count_reg <= cfg_data[OPERAND_WIDTH-1:0];
                default:           ; // drop writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Flow control
    // The whole pipeline advances together on en; it holds only while the
    // output register carries a word the sink has not taken. An input skid
    // word keeps ready registered, so ready never follows res_chan.ready
    // combinationally.
    // ------------------------------------------------------------------
    logic                     en;
    logic                     in_accept;
    logic                     skid_valid_reg;
    logic [OP_WIDTH-1:0]      skid_op_reg;
    logic [OPERAND_WIDTH-1:0] skid_left_reg;
    logic [OPERAND_WIDTH-1:0] skid_right_reg;
    logic                     out_valid_reg;
    logic [MODULUS_WIDTH-1:0] out_res_a_reg;
    logic [MODULUS_WIDTH-1:0] out_res_b_reg;
    logic                     out_err_reg;

    assign en            = !out_valid_reg || res_chan.ready;
    assign op_chan.ready = !skid_valid_reg;
    assign in_accept     = op_chan.valid && op_chan.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg && en)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (in_accept && !en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && !en)
        begin
            skid_op_reg    <= op_chan.operation;
            skid_left_reg  <= op_chan.left_operand;
            skid_right_reg <= op_chan.right_operand;
        end
    end

    // ------------------------------------------------------------------
    // Entry: the skid word goes first, otherwise the word on the channel
    // ------------------------------------------------------------------
    logic [OP_WIDTH-1:0]      entry_op;
    logic [OPERAND_WIDTH-1:0] entry_left;
    logic [OPERAND_WIDTH-1:0] entry_right;
    side_t                    entry_side;

    always_comb
    begin
        if (skid_valid_reg)
        begin
            entry_op    = skid_op_reg;
            entry_left  = skid_left_reg;
            entry_right = skid_right_reg;
        end
        else
        begin
            entry_op    = op_chan.operation;
            entry_left  = op_chan.left_operand;
            entry_right = op_chan.right_operand;
        end
        entry_side.valid     = skid_valid_reg || in_accept;
        entry_side.op        = entry_op;
        entry_side.range_err = (entry_left >= count_reg) || (entry_right >= count_reg);
    end

    // ------------------------------------------------------------------
    // First chain: reduce each operand by both moduli, one bit per cell,
    // operand left-aligned so its MSB enters first.
    // ------------------------------------------------------------------
    cell_data_t c1 [NUM_LANES1][OPERAND_WIDTH+1];
    side_t      side1_reg [OPERAND_WIDTH];

    assign c1[LANE_LA][0] = '{rem: '0,
        value: VALUE_WIDTH'(entry_left) << (VALUE_WIDTH - OPERAND_WIDTH)};
    assign c1[LANE_RA][0] = '{rem: '0,
        value: VALUE_WIDTH'(entry_right) << (VALUE_WIDTH - OPERAND_WIDTH)};
    assign c1[LANE_LB][0] = c1[LANE_LA][0];
    assign c1[LANE_RB][0] = c1[LANE_RA][0];

    for (genvar l = 0; l < NUM_LANES1; l++)
    begin : g_lane1
        for (genvar k = 0; k < OPERAND_WIDTH; k++)
        begin : g_cell
            trma_reduce_cell u_cell (
                .clk      (clk),
                .en       (en),
                .modulus  ((l < LANE_LB) ? mod_a_reg : mod_b_reg),
                .data_in  (c1[l][k]),
                .data_out (c1[l][k+1])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < OPERAND_WIDTH; k++)
            begin
                side1_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            side1_reg[0] <= entry_side;
            for (int k = 1; k < OPERAND_WIDTH; k++)
            begin
                side1_reg[k] <= side1_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Combine: add, subtract with modulus offset, or multiply
    // ------------------------------------------------------------------
    logic [PRODUCT_WIDTH-1:0] comb_a;
    logic [PRODUCT_WIDTH-1:0] comb_b;
    side_t                    side_c_reg;

    trma_combine u_combine_a (
        .clk     (clk),
        .en      (en),
        .op      (side1_reg[OPERAND_WIDTH-1].op),
        .modulus (mod_a_reg),
        .rx      (c1[LANE_LA][OPERAND_WIDTH].rem),
        .ry      (c1[LANE_RA][OPERAND_WIDTH].rem),
        .value   (comb_a)
    );

    trma_combine u_combine_b (
        .clk     (clk),
        .en      (en),
        .op      (side1_reg[OPERAND_WIDTH-1].op),
        .modulus (mod_b_reg),
        .rx      (c1[LANE_LB][OPERAND_WIDTH].rem),
        .ry      (c1[LANE_RB][OPERAND_WIDTH].rem),
        .value   (comb_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_c_reg <= '0;
        end
        else if (en)
        begin
            side_c_reg <= side1_reg[OPERAND_WIDTH-1];
        end
    end

    // ------------------------------------------------------------------
    // Second chain: reduce the combined value by its modulus
    // ------------------------------------------------------------------
    cell_data_t c2 [NUM_LANES2][PRODUCT_WIDTH+1];
    side_t      side2_reg [PRODUCT_WIDTH];

    assign c2[0][0] = '{rem: '0,
        value: VALUE_WIDTH'(comb_a) << (VALUE_WIDTH - PRODUCT_WIDTH)};
    assign c2[1][0] = '{rem: '0,
        value: VALUE_WIDTH'(comb_b) << (VALUE_WIDTH - PRODUCT_WIDTH)};

    for (genvar l = 0; l < NUM_LANES2; l++)
    begin : g_lane2
        for (genvar k = 0; k < PRODUCT_WIDTH; k++)
        begin : g_cell
            trma_reduce_cell u_cell (
                .clk      (clk),
                .en       (en),
                .modulus  ((l == 0) ? mod_a_reg : mod_b_reg),
                .data_in  (c2[l][k]),
                .data_out (c2[l][k+1])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PRODUCT_WIDTH; k++)
            begin
                side2_reg[k] <= '0;
            end
        end
        else if (en)
        begin
            side2_reg[0] <= side_c_reg;
            for (int k = 1; k < PRODUCT_WIDTH; k++)
            begin
                side2_reg[k] <= side2_reg[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: zero the residues on a range error, and zero the
    // residue of a modulus set to 0 (the cells give no meaningful value).
    // ------------------------------------------------------------------
    side_t last_side;

    assign last_side = side2_reg[PRODUCT_WIDTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= last_side.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_err_reg   <= last_side.range_err;
            out_res_a_reg <= (last_side.range_err || (mod_a_reg == '0)) ?
                             '0 : c2[0][PRODUCT_WIDTH].rem;
            out_res_b_reg <= (last_side.range_err || (mod_b_reg == '0)) ?
                             '0 : c2[1][PRODUCT_WIDTH].rem;
        end
    end

    assign res_chan.valid       = out_valid_reg;
    assign res_chan.residue_a   = out_res_a_reg;
    assign res_chan.residue_b   = out_res_b_reg;
    assign res_chan.range_error = out_err_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TRMA_ASSERT_NEXT(a_skid_capture, clk, rst_n, in_accept && !en, skid_valid_reg,
        "word accepted during a stall was not captured in the skid buffer")
    `TRMA_ASSERT_NEXT(a_skid_drain, clk, rst_n, skid_valid_reg && en, !skid_valid_reg,
        "skid word was not released into the pipeline")
    `TRMA_ASSERT_NOW(a_err_zero, clk, rst_n, out_valid_reg && out_err_reg,
        (out_res_a_reg == '0) && (out_res_b_reg == '0),
        "range error word carries nonzero residues")

endmodule

/* hdl/trma_reduce_cell.sv */
// ----------------------------------------------------------------------------
// trma_reduce_cell
// One restoring-reduction step: bring in the next value bit, subtract the
// modulus when the partial remainder reaches it.
// ----------------------------------------------------------------------------
module trma_reduce_cell
    import trma_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [MODULUS_WIDTH-1:0] modulus,
    input  cell_data_t               data_in,
    output cell_data_t               data_out
);

    cell_data_t             data_reg;
    cell_data_t             data_next;
    logic [MODULUS_WIDTH:0] trial;
    logic [MODULUS_WIDTH:0] diff;

    always_comb
    begin
        trial = {data_in.rem, data_in.value[VALUE_WIDTH-1]};
        diff  = trial - {1'b0, modulus};
        data_next.value = data_in.value << 1;
        if (trial >= {1'b0, modulus})
        begin
            data_next.rem = diff[MODULUS_WIDTH-1:0];
        end
        else
        begin
            data_next.rem = trial[MODULUS_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign data_out = data_reg;

endmodule

/* hdl/trma_combine.sv */
// ----------------------------------------------------------------------------
// trma_combine
// Combine two residues by the operation code; register the raw result for
// the second reduction chain.
// ----------------------------------------------------------------------------
module trma_combine
    import trma_pkg::*;
(
    input  logic                     clk,
    input  logic                     en,
    input  logic [OP_WIDTH-1:0]      op,
    input  logic [MODULUS_WIDTH-1:0] modulus,
    input  logic [MODULUS_WIDTH-1:0] rx,
    input  logic [MODULUS_WIDTH-1:0] ry,
    output logic [PRODUCT_WIDTH-1:0] value
);

    logic [PRODUCT_WIDTH-1:0] value_reg;
    logic [PRODUCT_WIDTH-1:0] value_next;

    always_comb
    begin
        unique case (op)
            OP_ADD:  value_next = PRODUCT_WIDTH'(rx) + PRODUCT_WIDTH'(ry);
            // ry is below the modulus, so this never goes negative
            OP_SUB:  value_next = PRODUCT_WIDTH'(modulus) + PRODUCT_WIDTH'(rx)
                                  - PRODUCT_WIDTH'(ry);
            OP_MUL:  value_next = PRODUCT_WIDTH'(rx) * PRODUCT_WIDTH'(ry);
            default: value_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

/* sim/tb_two_modulus_residue_alu_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the two-modulus residue ALU
// Drives operation words through the valid/ready channel under several
// modulus and element-count settings. A directed table runs first, then
// random phases. Every result word is checked field by field against its
// table entry or an in-bench residue predictor. Both sides idle in random
// bursts; one phase holds the result side off long enough to back up the input.
// ----------------------------------------------------------------------------
module tb_two_modulus_residue_alu_unit;
    import trma_pkg::*;

    // Operation code the block leaves unused, and a register index past the list
    localparam logic [OP_WIDTH-1:0]        OP_UNUSED  = 2'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;

    localparam int PIPE_LATENCY     = OPERAND_WIDTH + PRODUCT_WIDTH + 2;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int RANDOM_PHASES    = 9;
    localparam int PRESSURE_PHASE   = 2;

    typedef struct packed {
        logic [MODULUS_WIDTH-1:0] residue_a;
        logic [MODULUS_WIDTH-1:0] residue_b;
        logic                     range_error;
    } residue_word_t;

    localparam residue_word_t ZERO_WORD  = '{16'd0, 16'd0, 1'b0};
    localparam residue_word_t RANGE_WORD = '{16'd0, 16'd0, 1'b1};

    // ROW_KNOWN carries its expected word; ROW_PREDICT goes through the predictor;
    // ROW_CONFIG writes register reg_index with the value held in left.
    typedef enum logic [1:0] {ROW_KNOWN, ROW_PREDICT, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_INDEX_WIDTH-1:0] reg_index;
        logic [OP_WIDTH-1:0]        op;
        logic [OPERAND_WIDTH-1:0]   left;
        logic [OPERAND_WIDTH-1:0]   right;
        residue_word_t              known;
    } stimulus_row_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data;

    trma_in_if  op_chan ();
    trma_out_if res_chan ();

    two_modulus_residue_alu_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op_chan   (op_chan),
        .res_chan  (res_chan)
    );

    // Predictor's copy of the configuration registers
    logic [MODULUS_WIDTH-1:0] cur_modulus_a;
    logic [MODULUS_WIDTH-1:0] cur_modulus_b;
    logic [OPERAND_WIDTH-1:0] cur_element_count;

    residue_word_t   pending_words[$];
    stimulus_row_t   directed_rows[$];
    int              mismatches;
    int              cycle_count;
    bit              source_gaps;
    bit              sink_stalls;
    bit              long_hold_req;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Reduce both operands by m, combine them, reduce again. A zero modulus
    // yields zero; the unused code yields zero as well.
    function automatic logic [MODULUS_WIDTH-1:0] combine_residues(
        input logic [OP_WIDTH-1:0]      op,
        input logic [OPERAND_WIDTH-1:0] x,
        input logic [OPERAND_WIDTH-1:0] y,
        input logic [MODULUS_WIDTH-1:0] m
    );
        logic [63:0] m64;
        logic [63:0] rx;
        logic [63:0] ry;
        logic [63:0] r;
        if (m == '0)
            return '0;
        m64 = 64'(m);
        rx  = 64'(x) % m64;
        ry  = 64'(y) % m64;
        case (op)
            OP_ADD:  r = (rx + ry) % m64;
            OP_SUB:  r = (m64 + rx - ry) % m64;
            OP_MUL:  r = (rx * ry) % m64;
            default: r = '0;
        endcase
        return r[MODULUS_WIDTH-1:0];
    endfunction

    function automatic residue_word_t predict_residue_word(
        input logic [OP_WIDTH-1:0]      op,
        input logic [OPERAND_WIDTH-1:0] left,
        input logic [OPERAND_WIDTH-1:0] right
    );
        residue_word_t w;
        w = ZERO_WORD;
        // Either operand at or past the element count flags the word
        if (left >= cur_element_count || right >= cur_element_count)
            w = RANGE_WORD;
        else begin
            w.residue_a = combine_residues(op, left, right, cur_modulus_a);
            w.residue_b = combine_residues(op, left, right, cur_modulus_b);
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Write one register and mirror it into the predictor. Unlisted indexes
    // are dropped by the block, so drop them here too.
    task automatic write_reg(input logic [CFG_INDEX_WIDTH-1:0] index,
                             input logic [CFG_DATA_WIDTH-1:0]  value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_MODULUS_A:     cur_modulus_a     = value[MODULUS_WIDTH-1:0];
            REG_MODULUS_B:     cur_modulus_b     = value[MODULUS_WIDTH-1:0];
            REG_ELEMENT_COUNT: cur_element_count = value[OPERAND_WIDTH-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Offer one operation word, hold it until accepted, then queue the
    // expected result word. Valid stays high across back-to-back words.
    task automatic send_word(input logic [OP_WIDTH-1:0]      op,
                             input logic [OPERAND_WIDTH-1:0] left,
                             input logic [OPERAND_WIDTH-1:0] right,
                             input bit                       has_known,
                             input residue_word_t            known);
        if (source_gaps && $urandom_range(0, 5) == 0) begin
            op_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        op_chan.valid         <= 1'b1;
        op_chan.operation     <= op;
        op_chan.left_operand  <= left;
        op_chan.right_operand <= right;
        do
            @(posedge clk);
        while (!op_chan.ready);
        pending_words.push_back(has_known ? known : predict_residue_word(op, left, right));
    endtask

    // Drop valid and wait for every outstanding word to come back
    task automatic wait_for_drain();
        op_chan.valid <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------------

    function automatic logic [MODULUS_WIDTH-1:0] pick_modulus();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'd1;
            2:       return 16'd2;
            3:       return 16'hFFFF;
            4:       return 16'd65521;
            default: return MODULUS_WIDTH'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [OPERAND_WIDTH-1:0] pick_element_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return 32'hFFFF_FFFF;
            2:       return OPERAND_WIDTH'($urandom_range(1, 64));
            3:       return $urandom;
            default: return $urandom_range(32'h4000_0000, 32'hFFFF_FFFF);
        endcase
    endfunction

    // Mostly in range; the rest sits on or past the boundary, or anywhere
    function automatic logic [OPERAND_WIDTH-1:0] pick_operand();
        case ($urandom_range(0, 15))
            0:       return $urandom;
            1:       return cur_element_count;
            2:       return (cur_element_count == '0) ? 32'hFFFF_FFFF : cur_element_count - 1;
            3:       return $urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF;
            default: return (cur_element_count == '0) ? $urandom
                                                      : $urandom_range(0, cur_element_count - 1);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------------

    // Hold ready low in random bursts, or for one long stretch on request
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        res_chan.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0)
                hold_left--;
            else if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD_CYCLES;
            end
            else if (sink_stalls && $urandom_range(0, 9) == 0)
                hold_left = $urandom_range(1, 19);
            res_chan.ready <= rst_n && (hold_left == 0);
        end
    end

    // Check each accepted result word against the oldest expectation
    always @(posedge clk) begin : result_check
        residue_word_t want;
        if (rst_n && res_chan.valid && res_chan.ready) begin
            if (pending_words.size() == 0) begin
                $error("unexpected result word: residue_a=%0d residue_b=%0d range_error=%0b",
                       res_chan.residue_a, res_chan.residue_b, res_chan.range_error);
                mismatches++;
            end
            else begin
                want = pending_words.pop_front();
                if (res_chan.residue_a !== want.residue_a) begin
                    $error("residue_a: expected %0d, actual %0d",
                           want.residue_a, res_chan.residue_a);
                    mismatches++;
                end
                if (res_chan.residue_b !== want.residue_b) begin
                    $error("residue_b: expected %0d, actual %0d",
                           want.residue_b, res_chan.residue_b);
                    mismatches++;
                end
                if (res_chan.range_error !== want.range_error) begin
                    $error("range_error: expected %0b, actual %0b",
                           want.range_error, res_chan.range_error);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int phase_words;
        logic [OP_WIDTH-1:0] op;

        mismatches    = 0;
        cycle_count   = 0;
        source_gaps   = 1'b1;
        sink_stalls   = 1'b1;
        long_hold_req = 1'b0;

        // Reset values of the registers
        cur_modulus_a     = 16'd1;
        cur_modulus_b     = 16'd1;
        cur_element_count = '0;

        rst_n                 <= 1'b0;
        cfg_we                <= 1'b0;
        cfg_index             <= '0;
        cfg_data              <= '0;
        op_chan.valid         <= 1'b0;
        op_chan.operation     <= OP_ADD;
        op_chan.left_operand  <= '0;
        op_chan.right_operand <= '0;

        // Directed table. Config rows carry the register value in left.
        // Out of reset the element count is zero: every operand is out of range.
        directed_rows.push_back('{ROW_KNOWN, REG_UNUSED, OP_ADD, 32'd0, 32'd0, RANGE_WORD});
        directed_rows.push_back('{ROW_KNOWN, REG_UNUSED, OP_MUL, 32'hFFFF_FFFF,
                                  32'hFFFF_FFFF, RANGE_WORD});
        // Widest modulus a and count, b = 65521; modulus writes drop upper data bits
        directed_rows.push_back('{ROW_CONFIG, REG_MODULUS_A, OP_ADD, 32'hFFFF_FFFF, 32'd0,
                                  ZERO_WORD});
        directed_rows.push_back('{ROW_CONFIG, REG_MODULUS_B, OP_ADD, 32'd65521, 32'd0,
                                  ZERO_WORD});
        directed_rows.push_back('{ROW_CONFIG, REG_ELEMENT_COUNT, OP_ADD, 32'hFFFF_FFFF, 32'd0,
                                  ZERO_WORD});
        directed_rows.push_back('{ROW_PREDICT, REG_UNUSED, OP_ADD, 32'hFFFF_FFFE,
                                  32'hFFFF_FFFE, ZERO_WORD});
        directed_rows.push_back('{ROW_PREDICT, REG_UNUSED, OP_SUB, 32'd0, 32'hFFFF_FFFE,
                                  ZERO_WORD});
        directed_rows.push_back('{ROW_PREDICT, REG_UNUSED, OP_MUL, 32'hFFFF_FFFE,
                                  32'hFFFF_FFFD, ZERO_WORD});
        directed_rows.push_back('{ROW_PREDICT, REG_UNUSED, OP_SUB, 32'd12345, 32'd12345,
                                  ZERO_WORD});
        directed_rows.push_back('{ROW_KNOWN, REG_UNUSED, OP_ADD, 32'hFFFF_FFFF, 32'd0,
                                  RANGE_WORD});
        directed_rows.push_back('{ROW_KNOWN, REG_UNUSED, OP_SUB, 32'd5, 32'hFFFF_FFFF,
                                  RANGE_WORD});
        // Unused operation code in range gives zero residues, no error
        directed_rows.push_back('{ROW_KNOWN, REG_UNUSED, OP_UNUSED, 32'hFFFF_FFFE, 32'd7,
                                  ZERO_WORD});
        // A write past the register list must change nothing
        directed_rows.push_back('{ROW_CONFIG, REG_UNUSED, OP_ADD, 32'd0, 32'd0, ZERO_WORD});
        directed_rows.push_back('{ROW_PREDICT, REG_UNUSED, OP_ADD, 32'd1, 32'd2, ZERO_WORD});
        // Zero first modulus, small count
        directed_rows.push_back('{ROW_CONFIG, REG_MODULUS_A, OP_ADD, 32'd0, 32'd0, ZERO_WORD});
        directed_rows.push_back('{ROW_CONFIG, REG_MODULUS_B, OP_ADD, 32'd7, 32'd0, ZERO_WORD});
        directed_rows.push_back('{ROW_CONFIG, REG_ELEMENT_COUNT, OP_ADD, 32'd100, 32'd0,
                                  ZERO_WORD});
        directed_rows.push_back('{ROW_PREDICT, REG_UNUSED, OP_ADD, 32'd50, 32'd60, ZERO_WORD});
        directed_rows.push_back('{ROW_KNOWN, REG_UNUSED, OP_ADD, 32'd99, 32'd100, RANGE_WORD});
        directed_rows.push_back('{ROW_PREDICT, REG_UNUSED, OP_MUL, 32'd99, 32'd98, ZERO_WORD});
        // Zero second modulus
        directed_rows.push_back('{ROW_CONFIG, REG_MODULUS_A, OP_ADD, 32'd7, 32'd0, ZERO_WORD});
        directed_rows.push_back('{ROW_CONFIG, REG_MODULUS_B, OP_ADD, 32'd0, 32'd0, ZERO_WORD});
        directed_rows.push_back('{ROW_PREDICT, REG_UNUSED, OP_SUB, 32'd3, 32'd10, ZERO_WORD});
        // Smallest moduli and a count of one: only zero is in range
        directed_rows.push_back('{ROW_CONFIG, REG_MODULUS_A, OP_ADD, 32'd1, 32'd0, ZERO_WORD});
        directed_rows.push_back('{ROW_CONFIG, REG_MODULUS_B, OP_ADD, 32'd1, 32'd0, ZERO_WORD});
        directed_rows.push_back('{ROW_CONFIG, REG_ELEMENT_COUNT, OP_ADD, 32'd1, 32'd0,
                                  ZERO_WORD});
        directed_rows.push_back('{ROW_KNOWN, REG_UNUSED, OP_MUL, 32'd0, 32'd0, ZERO_WORD});
        directed_rows.push_back('{ROW_KNOWN, REG_UNUSED, OP_MUL, 32'd0, 32'd1, RANGE_WORD});
        directed_rows.push_back('{ROW_KNOWN, REG_UNUSED, OP_SUB, 32'd1, 32'd0, RANGE_WORD});

        // Hold reset, then release it on an edge
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table; drain before every register write
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_CONFIG: begin
                    wait_for_drain();
                    write_reg(directed_rows[i].reg_index, directed_rows[i].left);
                end
                ROW_KNOWN:
                    send_word(directed_rows[i].op, directed_rows[i].left,
                              directed_rows[i].right, 1'b1, directed_rows[i].known);
                default:
                    send_word(directed_rows[i].op, directed_rows[i].left,
                              directed_rows[i].right, 1'b0, ZERO_WORD);
            endcase
        end

        // Random phases: fresh settings each phase, written only while idle
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            wait_for_drain();
            write_reg(REG_MODULUS_A, {16'($urandom), pick_modulus()});
            write_reg(REG_MODULUS_B, {16'($urandom), pick_modulus()});
            write_reg(REG_ELEMENT_COUNT, pick_element_count());
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, $urandom);

            phase_words = 60;
            if (phase == RANDOM_PHASES - 1) begin
                // Last stretch runs flat out on both sides
                source_gaps = 1'b0;
                sink_stalls = 1'b0;
            end
            else if (phase == PRESSURE_PHASE) begin
                // Keep offering while the result side holds off: the pipe
                // fills and input ready must drop
                source_gaps   = 1'b0;
                sink_stalls   = 1'b0;
                long_hold_req = 1'b1;
                phase_words   = 120;
            end
            else begin
                source_gaps = $urandom_range(0, 3) != 0;
                sink_stalls = $urandom_range(0, 3) != 0;
            end

            repeat (phase_words) begin
                op = ($urandom_range(0, 15) == 0) ? OP_UNUSED
                                                  : OP_WIDTH'($urandom_range(0, 2));
                send_word(op, pick_operand(), pick_operand(), 1'b0, ZERO_WORD);
            end
        end

        // Let the pipe run dry, then watch a little longer for stray words
        wait_for_drain();
        repeat (PIPE_LATENCY + 16) @(posedge clk);

        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
